FILE: rtl/core/spdr_pkg.sv
// shared types and constants for the pwm shadow store with dirty-range flush
// no dependencies
`timescale 1ns / 1ps

package spdr_pkg;

	localparam int PORT_W  = 4;
	localparam int LEVEL_W = 8;
	localparam int BASE_W  = 5;
	localparam int CFG_W   = 8;

	localparam logic [BASE_W-1:0]  BASE_RST     = 5'd2;
	localparam logic [LEVEL_W-1:0] AUTO_INC_RST = 8'd160;

	// configuration register indexes
	localparam logic REG_PWM_BASE = 1'b0;
	localparam logic REG_AUTO_INC = 1'b1;

	// request codes
	localparam logic [1:0] REQ_SET   = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_FLUSH = 2'd2;
	localparam logic [1:0] REQ_RSVD  = 2'd3;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_BURST = 2'd1,
		KIND_IDLE  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SET,
		ST_READ,
		ST_CMD,
		ST_DATA
	} state_t;

	typedef struct packed {
		logic              set_en;
		logic [PORT_W-1:0] idx;
		logic              mark;
		logic              clear;
	} dirty_upd_t;

	typedef struct packed {
		logic              any;
		logic [PORT_W-1:0] first_idx;
		logic [PORT_W-1:0] last_idx;
	} scan_res_t;

endpackage

FILE: rtl/core/spdr_ram.sv
// synchronous level memory, one write and one read port, registered read
// entries never written read as zero; depends on nothing
`timescale 1ns / 1ps

module spdr_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rdata_s1;
	logic             rvld_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_s1 <= vld_q[raddr];
			end
		end
	end

	assign rdata = rvld_s1 ? rdata_s1 : '0;

endmodule

FILE: rtl/core/spdr_scan.sv
// dirty mask register with first and last dirty port encoder
// depends on spdr_pkg
`timescale 1ns / 1ps

module spdr_scan #(
	parameter int NUM_PORTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spdr_pkg::dirty_upd_t upd,
	output spdr_pkg::scan_res_t  res
);

	import spdr_pkg::*;

	localparam int AW = $clog2(NUM_PORTS);

	logic [NUM_PORTS-1:0] mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (upd.clear) begin
			mask_q <= '0;
		end else if (upd.set_en) begin
			mask_q[upd.idx[AW-1:0]] <= upd.mark;
		end
	end

	always_comb begin
		res = '0;
		for (int i = NUM_PORTS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				res.first_idx = PORT_W'(i);
			end
		end
		for (int i = 0; i < NUM_PORTS; i++) begin
			if (mask_q[i]) begin
				res.last_idx = PORT_W'(i);
			end
		end
		res.any = |mask_q;
	end

endmodule

FILE: rtl/core/pwm_shadow_dirty_range_flush.sv
// top level: request sequencer, staged and sent level memories, output register
// depends on spdr_pkg, spdr_ram, spdr_scan
`timescale 1ns / 1ps

// Shadow store for PWM levels. One request is worked at a time. A set goes
// through ST_SET (the sent copy is read back to decide the dirty mark), a read
// waits in ST_READ through any output stall, and a flush goes through ST_CMD
// and then, if a port is dirty, ST_DATA per burst level, first..last dirty
// port, since every byte of the burst is fetched through the single read
// port of the staged level memory. The output register frees the input side:
// the next request is taken while the last result still waits to be taken.

module pwm_shadow_dirty_range_flush #(
	parameter int NUM_PORTS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [3:0] port,
	input  logic [7:0] new_level,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] data,
	output logic       last
);

	import spdr_pkg::*;

	localparam int AW = $clog2(NUM_PORTS);

	state_t              state_q, state_d;
	logic [BASE_W-1:0]   base_q;
	logic [LEVEL_W-1:0]  auto_inc_q;
	logic [PORT_W-1:0]   port_q, ptr_q, ptr_d;
	logic [LEVEL_W-1:0]  level_q;
	logic                zero_q, zero_d;
	logic                out_valid_q;
	kind_t               kind_q, ld_kind;
	logic [LEVEL_W-1:0]  data_q, ld_data;
	logic                last_q, ld_last;
	logic                load, out_free, in_acc, port_ok;
	logic                stg_we, stg_re, snt_we, snt_re;
	logic [AW-1:0]       stg_raddr;
	logic [LEVEL_W-1:0]  stg_rdata, snt_rdata;
	dirty_upd_t          upd;
	scan_res_t           scan;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign port_ok  = ({1'b0, port} < 5'(NUM_PORTS));

	spdr_ram #(.DEPTH(NUM_PORTS), .WIDTH(LEVEL_W)) u_staged (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (stg_we),
		.waddr (port[AW-1:0]),
		.wdata (new_level),
		.re    (stg_re),
		.raddr (stg_raddr),
		.rdata (stg_rdata)
	);

	spdr_ram #(.DEPTH(NUM_PORTS), .WIDTH(LEVEL_W)) u_sent (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (snt_we),
		.waddr (ptr_q[AW-1:0]),
		.wdata (stg_rdata),
		.re    (snt_re),
		.raddr (port[AW-1:0]),
		.rdata (snt_rdata)
	);

	spdr_scan #(.NUM_PORTS(NUM_PORTS)) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.upd   (upd),
		.res   (scan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		zero_d    = zero_q;
		load      = 1'b0;
		ld_kind   = KIND_READ;
		ld_data   = '0;
		ld_last   = 1'b1;
		stg_we    = 1'b0;
		stg_re    = 1'b0;
		stg_raddr = port[AW-1:0];
		snt_we    = 1'b0;
		snt_re    = 1'b0;
		upd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (req_type)
						REQ_SET: begin
							if (port_ok) begin
								stg_we  = 1'b1;
								snt_re  = 1'b1;
								state_d = ST_SET;
							end
						end
						REQ_READ: begin
							stg_re  = 1'b1;
							zero_d  = !port_ok;
							state_d = ST_READ;
						end
						REQ_FLUSH: begin
							state_d = ST_CMD;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SET: begin
				upd.set_en = 1'b1;
				upd.idx    = port_q;
				upd.mark   = (level_q != snt_rdata);
				state_d    = ST_IDLE;
			end
			ST_READ: begin
				if (out_free) begin
					load    = 1'b1;
					ld_kind = KIND_READ;
					ld_data = zero_q ? '0 : stg_rdata;
					state_d = ST_IDLE;
				end
			end
			ST_CMD: begin
				if (out_free) begin
					load = 1'b1;
					if (!scan.any) begin
						ld_kind = KIND_IDLE;
						state_d = ST_IDLE;
					end else begin
						ld_kind   = KIND_BURST;
						ld_data   = auto_inc_q |
							LEVEL_W'({1'b0, base_q} + {2'b00, scan.first_idx});
						ld_last   = 1'b0;
						stg_re    = 1'b1;
						stg_raddr = scan.first_idx[AW-1:0];
						ptr_d     = scan.first_idx;
						state_d   = ST_DATA;
					end
				end
			end
			ST_DATA: begin
				if (out_free) begin
					load    = 1'b1;
					ld_kind = KIND_BURST;
					ld_data = stg_rdata;
					ld_last = (ptr_q == scan.last_idx);
					snt_we  = 1'b1;
					if (ptr_q == scan.last_idx) begin
						upd.clear = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						stg_re    = 1'b1;
						ptr_d     = ptr_q + 4'd1;
						stg_raddr = ptr_d[AW-1:0];
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= BASE_RST;
			auto_inc_q  <= AUTO_INC_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_PWM_BASE: base_q     <= cfg_data[BASE_W-1:0];
					REG_AUTO_INC: auto_inc_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			port_q  <= port;
			level_q <= new_level;
		end
		ptr_q  <= ptr_d;
		zero_q <= zero_d;
		if (load) begin
			kind_q <= ld_kind;
			data_q <= ld_data;
			last_q <= ld_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign data      = data_q;
	assign last      = last_q;

	a_data_needs_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DATA |-> scan.any)
		else $error("burst data phase with empty dirty mask");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DATA |-> (ptr_q >= scan.first_idx) && (ptr_q <= scan.last_idx))
		else $error("burst pointer outside dirty range");

	a_flush_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DATA && out_free && ptr_q == scan.last_idx
		|=> !scan.any && state_q == ST_IDLE && out_valid_q && last_q)
		else $error("flush end did not clear dirty mask");

	a_idle_result_single: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMD && out_free && !scan.any
		|=> out_valid_q && kind_q == KIND_IDLE && last_q && data_q == '0)
		else $error("no-work result malformed");

endmodule
